// ===== src/srl_pkg.sv =====
// Shared types, constants and helpers for the S-record loader.
// Used by srl_parse, srl_fifo, srl_emit and srecord_memory_loader.
package srl_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_S  = 8'h53;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_TYPE       = 4'd1,
        PH_CNT_HI     = 4'd2,
        PH_CNT_LO     = 4'd3,
        PH_SKIPCNT_HI = 4'd4,
        PH_SKIPCNT_LO = 4'd5,
        PH_ADDR_HI    = 4'd6,
        PH_ADDR_LO    = 4'd7,
        PH_DATA_HI    = 4'd8,
        PH_DATA_LO    = 4'd9,
        PH_SKIP_LINE  = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_ENTRY    = 2'd1,
        KIND_BAD_HEX  = 2'd2,
        KIND_BAD_TYPE = 2'd3
    } kind_t;

    // One classified event handed from the parser to the output stage
    typedef struct packed {
        kind_t       kind;
        logic [31:0] addr;
        logic [7:0]  data;
    } event_t;

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

// ===== src/srl_parse.sv =====
// Character parser: walks the record syntax and pushes write, entry and
// error events. Depends on srl_pkg.
module srl_parse import srl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        char_valid,
    input  logic [7:0]  char_in,
    input  logic        queue_full,
    output logic        char_ready,
    output logic        ev_push,
    output event_t      ev_data
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  left_reg, left_next;
    logic        halted_reg, halted_next;

    logic        take;
    logic [4:0]  hex;
    logic [7:0]  byte_val;
    logic [31:0] addr_shift;
    logic [7:0]  left_dec;

    assign char_ready = !queue_full;
    assign take       = char_valid && char_ready;
    assign hex        = hex_decode(char_in);
    assign byte_val   = {nibble_reg, hex[3:0]};
    assign addr_shift = {addr_reg[23:0], byte_val};
    assign left_dec   = left_reg - 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LINE_START;
            kind_reg   <= 4'd0;
            nibble_reg <= 4'd0;
            count_reg  <= 8'd0;
            addr_reg   <= 32'd0;
            left_reg   <= 8'd0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            halted_reg <= halted_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        nibble_next  = nibble_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        halted_next  = halted_reg;
        ev_push      = 1'b0;
        ev_data.kind = KIND_WRITE;
        ev_data.addr = 32'd0;
        ev_data.data = 8'd0;

        if (take && !halted_reg) begin
            unique case (phase_reg)
                PH_LINE_START: begin
                    if (char_in == CH_S) begin
                        phase_next = PH_TYPE;
                    end else if (char_in != CH_LF) begin
                        phase_next = PH_SKIP_LINE;
                    end
                end
                PH_TYPE: begin
                    if (char_in >= 8'h31 && char_in <= 8'h33) begin
                        kind_next  = char_in[3:0];
                        phase_next = PH_CNT_HI;
                    end else if (char_in >= 8'h37 && char_in <= 8'h39) begin
                        kind_next  = char_in[3:0];
                        phase_next = PH_SKIPCNT_HI;
                    end else if (char_in == 8'h30 || (char_in >= 8'h34 && char_in <= 8'h36)) begin
                        phase_next = PH_SKIP_LINE;
                    end else begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_TYPE;
                        halted_next  = 1'b1;
                    end
                end
                PH_SKIPCNT_HI, PH_SKIPCNT_LO: begin
                    if (char_in == CH_LF) begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_HEX;
                        halted_next  = 1'b1;
                    end else if (phase_reg == PH_SKIPCNT_HI) begin
                        phase_next = PH_SKIPCNT_LO;
                    end else begin
                        left_next  = 8'd11 - {4'd0, kind_reg};
                        addr_next  = 32'd0;
                        phase_next = PH_ADDR_HI;
                    end
                end
                PH_CNT_HI, PH_ADDR_HI, PH_DATA_HI: begin
                    if (!hex[4]) begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_HEX;
                        halted_next  = 1'b1;
                    end else begin
                        nibble_next = hex[3:0];
                        priority case (phase_reg)
                            PH_CNT_HI:  phase_next = PH_CNT_LO;
                            PH_ADDR_HI: phase_next = PH_ADDR_LO;
                            default:    phase_next = PH_DATA_LO;
                        endcase
                    end
                end
                PH_CNT_LO: begin
                    if (!hex[4]) begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_HEX;
                        halted_next  = 1'b1;
                    end else begin
                        count_next = byte_val;
                        left_next  = {4'd0, kind_reg} + 8'd1;
                        addr_next  = 32'd0;
                        phase_next = PH_ADDR_HI;
                    end
                end
                PH_ADDR_LO: begin
                    if (!hex[4]) begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_HEX;
                        halted_next  = 1'b1;
                    end else begin
                        addr_next = addr_shift;
                        left_next = left_dec;
                        if (left_dec != 8'd0) begin
                            phase_next = PH_ADDR_HI;
                        end else if (kind_reg >= 4'd7) begin
                            phase_next = PH_SKIP_LINE;
                            // zero entry address: keep loading
                            if (addr_shift != 32'd0) begin
                                ev_push      = 1'b1;
                                ev_data.kind = KIND_ENTRY;
                                ev_data.addr = addr_shift;
                                halted_next  = 1'b1;
                            end
                        end else if (count_reg > ({4'd0, kind_reg} + 8'd2)) begin
                            left_next  = count_reg - {4'd0, kind_reg} - 8'd2;
                            phase_next = PH_DATA_HI;
                        end else begin
                            phase_next = PH_SKIP_LINE;
                        end
                    end
                end
                PH_DATA_LO: begin
                    if (!hex[4]) begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_BAD_HEX;
                        halted_next  = 1'b1;
                    end else begin
                        ev_push      = 1'b1;
                        ev_data.kind = KIND_WRITE;
                        ev_data.addr = addr_reg;
                        ev_data.data = byte_val;
                        addr_next    = addr_reg + 32'd1;
                        left_next    = left_dec;
                        phase_next   = (left_dec != 8'd0) ? PH_DATA_HI : PH_SKIP_LINE;
                    end
                end
                default: begin
                    phase_next = (char_in == CH_LF) ? PH_LINE_START : PH_SKIP_LINE;
                end
            endcase
        end
    end

    // no event once halted
    assert property (@(posedge aclk) disable iff (!aresetn) halted_reg |-> !ev_push)
        else $error("event pushed while halted");

    // every terminating event halts the parser on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_push && ev_data.kind != KIND_WRITE) |=> halted_reg)
        else $error("terminating event did not halt");

    // events only come from accepted characters, so the queue has room
    assert property (@(posedge aclk) disable iff (!aresetn) ev_push |-> (take && !queue_full))
        else $error("event pushed without an accepted character");

endmodule

// ===== src/srl_fifo.sv =====
// Short register queue of parser events between front and back end.
// Depends on srl_pkg.
module srl_fifo import srl_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output event_t pop_data
);

    event_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push, do_pop;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (FIFO_AW+1)'(1);
                2'b01:   count_reg <= count_reg - (FIFO_AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== src/srl_emit.sv =====
// Output stage: turns queued events into lane-masked word writes or status
// beats and holds them in the result register. Depends on srl_pkg.
module srl_emit import srl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ev_valid,
    input  event_t      ev_data,
    output logic        ev_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [29:0] m_word_index,
    output logic [3:0]  m_byte_mask,
    output logic [31:0] m_write_data
);

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [29:0] index_reg;
    logic [3:0]  mask_reg;
    logic [31:0] data_reg;

    logic [1:0]  lane;
    logic [29:0] index_next;
    logic [3:0]  mask_next;
    logic [31:0] data_next;

    assign ev_pop = ev_valid && (!valid_reg || m_ready);
    assign lane   = ev_data.addr[1:0];

    always_comb begin
        index_next = 30'd0;
        mask_next  = 4'd0;
        data_next  = 32'd0;
        unique case (ev_data.kind)
            KIND_WRITE: begin
                index_next = ev_data.addr[31:2];
                mask_next  = 4'b0001 << lane;
                data_next  = {24'd0, ev_data.data} << {lane, 3'b000};
            end
            KIND_ENTRY: data_next = ev_data.addr;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ev_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            kind_reg  <= ev_data.kind;
            index_reg <= index_next;
            mask_reg  <= mask_next;
            data_reg  <= data_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_kind       = kind_reg;
    assign m_word_index = index_reg;
    assign m_byte_mask  = mask_reg;
    assign m_write_data = data_reg;

endmodule

// ===== src/srecord_memory_loader.sv =====
// Throughput: one character per cycle; s_ready drops only when the event queue is full.
// Path: an event enters the queue at the character's accepting edge; it is then loaded into
// the result register once that register is empty or being taken, and m_valid rises.
// Reset (aresetn low, synchronous) returns the parser to line start, clears the halt
// flag, empties the event queue and drops m_valid; payload registers keep their values.
// After an entry, bad hex or bad type beat the loader ignores all input until reset.
module srecord_memory_loader import srl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [29:0] m_word_index,
    output logic [3:0]  m_byte_mask,
    output logic [31:0] m_write_data
);

    // Front end to queue
    logic   q_full;
    logic   q_push;
    event_t q_in;

    // Queue to back end
    logic   q_not_empty;
    logic   q_pop;
    event_t q_out;

    // Front end: classify each character beat and update the record syntax state
    srl_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (s_valid),
        .char_in    (s_char_in),
        .queue_full (q_full),
        .char_ready (s_ready),
        .ev_push    (q_push),
        .ev_data    (q_in)
    );

    // Decouple parser from the output handshake so each side can stall alone
    srl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // Back end: place data bytes into their lanes and hold the result beat
    srl_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ev_valid     (q_not_empty),
        .ev_data      (q_out),
        .ev_pop       (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_word_index (m_word_index),
        .m_byte_mask  (m_byte_mask),
        .m_write_data (m_write_data)
    );

endmodule
